[design/mdd_pkg.sv]
// mdd_pkg: shared types and constants for the motion direction detector
// used by mdd_queue, mdd_engine and motion_direction_detector_core
`timescale 1ns / 1ps

package mdd_pkg;

    localparam int AXIS_W    = 16;
    localparam int THR_W     = 15;
    localparam int SUM_OUT_W = 20;
    localparam int CFG_AW    = 2;

    localparam logic [CFG_AW-1:0] CFG_NEG_THR    = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_ENERGY_THR = 2'd1;

    localparam logic [THR_W-1:0] NEG_THR_RESET    = 15'd819;
    localparam logic [THR_W-1:0] ENERGY_THR_RESET = 15'd655;

    localparam logic [1:0] LAST_NONE = 2'd0;
    localparam logic [1:0] LAST_NEG  = 2'd1;
    localparam logic [1:0] LAST_POS  = 2'd2;

    localparam logic [SUM_OUT_W-1:0] SUM_OUT_MAX = 20'hFFFFF;

    typedef struct packed {
        logic signed [AXIS_W-1:0] x;
        logic signed [AXIS_W-1:0] y;
        logic signed [AXIS_W-1:0] z;
    } t_sample;

    typedef struct packed {
        logic [THR_W-1:0] neg_thr;
        logic [THR_W-1:0] energy_thr;
    } t_cfg;

endpackage

[design/mdd_queue.sv]
// mdd_queue: two-entry sample queue between the input port and the engine
// depends on mdd_pkg
`timescale 1ns / 1ps

module mdd_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  mdd_pkg::t_sample i_sample,
    output logic            o_valid,
    input  logic            i_ready,
    output mdd_pkg::t_sample o_sample
);

    mdd_pkg::t_sample r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       w_push;
    logic       w_pop;

    assign o_ready  = (r_count != 2'd2);
    assign o_valid  = (r_count != 2'd0);
    assign o_sample = r_mem[r_rd_ptr];
    assign w_push   = i_valid && o_ready;
    assign w_pop    = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[design/mdd_engine.sv]
// mdd_engine: sample ring, window scan, direction decision and result register
// depends on mdd_pkg
`timescale 1ns / 1ps

module mdd_engine #(
    parameter int WINDOW = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  mdd_pkg::t_cfg                    i_cfg,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  mdd_pkg::t_sample                 i_sample,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic                             o_direction,
    output logic [mdd_pkg::SUM_OUT_W-1:0]    o_energy_sum
);

    localparam int WP_W    = $clog2(WINDOW);
    localparam int IDX_W   = $clog2(WINDOW + 1);
    localparam int NEED_W  = $clog2(3 * 32768 * WINDOW + 1);
    localparam int ACC_W   = (NEED_W > mdd_pkg::SUM_OUT_W) ? NEED_W : mdd_pkg::SUM_OUT_W;
    localparam int THR_MUL = 3 * WINDOW;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    t_state                r_state;
    mdd_pkg::t_sample      r_ring [WINDOW];
    mdd_pkg::t_sample      r_rd_data;
    logic [WINDOW-1:0]     r_filled;
    logic [WP_W-1:0]       r_wp;
    logic [IDX_W-1:0]      r_idx;
    logic                  r_rd_vld;
    logic                  r_rd_ok;
    logic                  r_rd_first;
    logic                  r_rd_last;
    logic [ACC_W-1:0]      r_acc;
    logic [ACC_W-1:0]      r_thr;
    logic                  r_first;
    logic                  r_agree;
    logic [1:0]            r_last;
    logic                  r_ovalid;
    logic                  r_odir;
    logic [mdd_pkg::SUM_OUT_W-1:0] r_osum;

    logic                  w_push;
    logic [WP_W-1:0]       w_rd_addr;
    mdd_pkg::t_sample      w_ent;
    logic [16:0]           w_ex, w_ey, w_ez;
    logic [16:0]           w_ax, w_ay, w_az;
    logic signed [16:0]    w_lim;
    logic                  w_nx, w_ny, w_nz;
    logic                  w_local;
    logic [18:0]           w_ent_sum;
    logic [1:0]            w_code;
    logic                  w_emit;
    logic                  w_load;
    logic [mdd_pkg::SUM_OUT_W-1:0] w_sat;

    assign w_push    = (r_state == S_IDLE) && i_valid;
    assign o_ready   = w_push;
    assign w_rd_addr = r_idx[WP_W-1:0];

    always_comb begin
        w_ent = r_rd_ok ? r_rd_data : '0;
        w_ex  = {w_ent.x[15], w_ent.x};
        w_ey  = {w_ent.y[15], w_ent.y};
        w_ez  = {w_ent.z[15], w_ent.z};
        w_ax  = w_ex[16] ? (~w_ex + 17'd1) : w_ex;
        w_ay  = w_ey[16] ? (~w_ey + 17'd1) : w_ey;
        w_az  = w_ez[16] ? (~w_ez + 17'd1) : w_ez;
        w_lim = 17'sd0 - $signed({2'b00, i_cfg.neg_thr});
        w_nx  = $signed(w_ex) < w_lim;
        w_ny  = $signed(w_ey) < w_lim;
        w_nz  = $signed(w_ez) < w_lim;
        w_local   = ~(w_nx ^ w_ny ^ w_nz);
        w_ent_sum = 19'(w_ax) + 19'(w_ay) + 19'(w_az);
    end

    always_comb begin
        w_code = r_first ? mdd_pkg::LAST_POS : mdd_pkg::LAST_NEG;
        w_emit = r_agree && (r_acc >= r_thr) && (w_code != r_last);
        w_load = (r_state == S_DONE) && w_emit && (!r_ovalid || i_ready);
        w_sat  = (r_acc > ACC_W'(mdd_pkg::SUM_OUT_MAX)) ? mdd_pkg::SUM_OUT_MAX
                                                        : r_acc[mdd_pkg::SUM_OUT_W-1:0];
    end

    // ring storage, registered read
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_ring[r_wp] <= i_sample;
        end
        r_rd_data <= r_ring[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_filled <= '0;
            r_wp     <= '0;
            r_idx    <= '0;
            r_rd_vld <= 1'b0;
            r_last   <= mdd_pkg::LAST_NONE;
            r_ovalid <= 1'b0;
        end else begin
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_push) begin
                        r_filled[r_wp] <= 1'b1;
                        r_wp     <= (r_wp == WP_W'(WINDOW - 1)) ? '0 : r_wp + 1'b1;
                        r_idx    <= '0;
                        r_rd_vld <= 1'b0;
                        r_acc    <= '0;
                        r_agree  <= 1'b1;
                        r_thr    <= ACC_W'(i_cfg.energy_thr) * ACC_W'(THR_MUL);
                        r_state  <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_idx < IDX_W'(WINDOW)) begin
                        r_rd_vld   <= 1'b1;
                        r_rd_ok    <= r_filled[w_rd_addr];
                        r_rd_first <= (r_idx == '0);
                        r_rd_last  <= (r_idx == IDX_W'(WINDOW - 1));
                        r_idx      <= r_idx + 1'b1;
                    end else begin
                        r_rd_vld <= 1'b0;
                    end
                    if (r_rd_vld) begin
                        r_acc <= r_acc + ACC_W'(w_ent_sum);
                        if (r_rd_first) begin
                            r_first <= w_local;
                        end else if (w_local != r_first) begin
                            r_agree <= 1'b0;
                        end
                        if (r_rd_last) begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    if (!w_emit) begin
                        r_state <= S_IDLE;
                    end else if (w_load) begin
                        r_odir   <= r_first;
                        r_osum   <= w_sat;
                        r_last   <= w_code;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid      = r_ovalid;
    assign o_direction  = r_odir;
    assign o_energy_sum = r_osum;

endmodule

[design/motion_direction_detector_core.sv]
// motion_direction_detector_core: top level, config registers, queue and engine
// depends on mdd_pkg, mdd_queue, mdd_engine
// the engine accepts a new sample only once idle, i.e. after its serial scan over the ring
// memory (one entry per cycle, one read port) and its direction decision have finished;
// the two-entry input queue takes samples while the engine scans
// reset: synchronous active low; ring reads as zero, thresholds 819 and 655, nothing emitted
`timescale 1ns / 1ps

module motion_direction_detector_core #(
    parameter int WINDOW = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [mdd_pkg::CFG_AW-1:0]          i_cfg_addr,
    input  logic [mdd_pkg::THR_W-1:0]           i_cfg_wdata,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [mdd_pkg::AXIS_W-1:0]   i_accel_x,
    input  logic signed [mdd_pkg::AXIS_W-1:0]   i_accel_y,
    input  logic signed [mdd_pkg::AXIS_W-1:0]   i_accel_z,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic                                o_direction,
    output logic [mdd_pkg::SUM_OUT_W-1:0]       o_energy_sum
);

    mdd_pkg::t_cfg    r_cfg;
    mdd_pkg::t_sample w_in_sample;
    mdd_pkg::t_sample w_q_sample;
    logic             w_q_valid;
    logic             w_q_ready;

    assign w_in_sample.x = i_accel_x;
    assign w_in_sample.y = i_accel_y;
    assign w_in_sample.z = i_accel_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.neg_thr    <= mdd_pkg::NEG_THR_RESET;
            r_cfg.energy_thr <= mdd_pkg::ENERGY_THR_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                mdd_pkg::CFG_NEG_THR:    r_cfg.neg_thr    <= i_cfg_wdata;
                mdd_pkg::CFG_ENERGY_THR: r_cfg.energy_thr <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    mdd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_sample (w_in_sample),
        .o_valid  (w_q_valid),
        .i_ready  (w_q_ready),
        .o_sample (w_q_sample)
    );

    mdd_engine #(
        .WINDOW (WINDOW)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_valid      (w_q_valid),
        .o_ready      (w_q_ready),
        .i_sample     (w_q_sample),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_direction  (o_direction),
        .o_energy_sum (o_energy_sum)
    );

endmodule
